// File: design/idle_connection_timing_wheel_macros.svh
// Assertion macros for the idle-connection timing wheel.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef IDLE_CONNECTION_TIMING_WHEEL_MACROS_SVH
`define IDLE_CONNECTION_TIMING_WHEEL_MACROS_SVH
`ifndef SYNTHESIS
`define ICW_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("icw: forbidden condition seen");
`define ICW_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("icw: same-cycle implication failed");
`define ICW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("icw: next-cycle implication failed");
`else
`define ICW_ASSERT_NEVER(lbl, cond)
`define ICW_ASSERT_IMPLIES(lbl, ante, cons)
`define ICW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: design/icw_pkg.sv
// Package for the idle-connection timing wheel: sizes, opcodes, item types,
// controller states. No dependencies.
`default_nettype none
package icw_pkg;

    localparam int WHEEL_SLOTS = 30;
    localparam int MAX_CONN    = 64;

    localparam int SLOT_W = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
    localparam int CONN_W = (MAX_CONN > 1) ? $clog2(MAX_CONN) : 1;
    localparam int OP_W   = 2;
    localparam int ID_W   = 6;

    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_ACTIVE = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0] opcode;
        logic [ID_W-1:0] conn_id;
    } icw_evt_t;

    typedef struct packed {
        logic            kick_valid;
        logic [ID_W-1:0] kicked_conn;
        logic            last;
    } icw_res_t;

    typedef struct packed {
        logic     load;
        icw_res_t item;
    } icw_push_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_FINISH
    } icw_state_t;

endpackage
`default_nettype wire

// File: design/icw_slot_ram.sv
// Synchronous single-port-write, single-port-read RAM with registered read.
// Holds the slot number of each connection. No dependencies.
`default_nettype none
module icw_slot_ram #(
    parameter int DATA_W = 5,
    parameter int ADDR_W = 6
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: design/icw_out_buf.sv
// One-entry output register for result items.
// Depends on icw_pkg.
`default_nettype none
module icw_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire icw_pkg::icw_push_t push,
    output logic                   free,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output icw_pkg::icw_res_t      res
);

    logic              valid_reg;
    logic              valid_next;
    icw_pkg::icw_res_t data_reg;

    always_comb
    begin
        free       = !valid_reg || res_ready;
        valid_next = valid_reg;
        if (push.load)
        begin
            valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.load)
        begin
            data_reg <= push.item;
        end
    end

    assign res_valid = valid_reg;
    assign res       = data_reg;

endmodule
`default_nettype wire

// File: design/icw_ctrl.sv
// Controller: current slot, tracked bits, item decode and the tick scan over
// the slot RAM. Depends on icw_pkg and icw_slot_ram.
`default_nettype none
module icw_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               evt_valid,
    output logic                    evt_ready,
    input  wire icw_pkg::icw_evt_t  evt,
    input  wire logic               out_free,
    output icw_pkg::icw_push_t      push
);

    localparam int SLOT_W = icw_pkg::SLOT_W;
    localparam int CONN_W = icw_pkg::CONN_W;
    localparam int ID_W   = icw_pkg::ID_W;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(icw_pkg::WHEEL_SLOTS - 1);
    localparam logic [CONN_W-1:0] CONN_LAST = CONN_W'(icw_pkg::MAX_CONN - 1);

    icw_pkg::icw_state_t state_reg, state_next;
    logic [SLOT_W-1:0]          cur_reg, cur_next;
    logic [CONN_W-1:0]          idx_reg, idx_next;
    logic [CONN_W-1:0]          pend_reg, pend_next;
    logic                       pend_vld_reg, pend_vld_next;
    logic [icw_pkg::MAX_CONN-1:0] tracked_reg, tracked_next;

    logic              ram_we;
    logic              ram_re;
    logic [SLOT_W-1:0] ram_rdata;
    logic [CONN_W-1:0] evt_idx;
    logic              id_ok;
    logic              hit;

    assign evt_idx = evt.conn_id[CONN_W-1:0];
    assign id_ok   = {1'b0, evt.conn_id} < (ID_W + 1)'(icw_pkg::MAX_CONN);
    assign hit     = tracked_reg[idx_reg] && (ram_rdata == cur_reg);

    icw_slot_ram #(
        .DATA_W (SLOT_W),
        .ADDR_W (CONN_W)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (evt_idx),
        .wdata (cur_reg),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        tracked_next  = tracked_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        evt_ready     = 1'b0;
        push          = '0;

        unique case (state_reg)
            icw_pkg::ST_IDLE:
            begin
                evt_ready = 1'b1;
                if (evt_valid)
                begin
                    case (evt.opcode)
                        icw_pkg::OP_TICK:
                        begin
                            cur_next      = (cur_reg == SLOT_LAST) ? '0
                                                                   : cur_reg + SLOT_W'(1);
                            idx_next      = '0;
                            pend_vld_next = 1'b0;
                            state_next    = icw_pkg::ST_READ;
                        end
                        icw_pkg::OP_ACTIVE:
                        begin
                            if (id_ok)
                            begin
                                ram_we                = 1'b1;
                                tracked_next[evt_idx] = 1'b1;
                            end
                        end
                        icw_pkg::OP_REMOVE:
                        begin
                            if (id_ok)
                            begin
                                tracked_next[evt_idx] = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            icw_pkg::ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = icw_pkg::ST_CHECK;
            end
            icw_pkg::ST_CHECK:
            begin
                if (!(hit && pend_vld_reg && !out_free))
                begin
                    if (hit)
                    begin
                        tracked_next[idx_reg] = 1'b0;
                        pend_next             = idx_reg;
                        pend_vld_next         = 1'b1;
                        if (pend_vld_reg)
                        begin
                            push.load             = 1'b1;
                            push.item.kick_valid  = 1'b1;
                            push.item.kicked_conn = ID_W'(pend_reg);
                            push.item.last        = 1'b0;
                        end
                    end
                    if (idx_reg == CONN_LAST)
                    begin
                        state_next = icw_pkg::ST_FINISH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CONN_W'(1);
                        state_next = icw_pkg::ST_READ;
                    end
                end
            end
            icw_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    push.load             = 1'b1;
                    push.item.kick_valid  = pend_vld_reg;
                    push.item.kicked_conn = pend_vld_reg ? ID_W'(pend_reg) : '0;
                    push.item.last        = 1'b1;
                    state_next            = icw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = icw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= icw_pkg::ST_IDLE;
            cur_reg      <= '0;
            idx_reg      <= '0;
            pend_vld_reg <= 1'b0;
            tracked_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            idx_reg      <= idx_next;
            pend_vld_reg <= pend_vld_next;
            tracked_reg  <= tracked_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

endmodule
`default_nettype wire

// File: design/idle_connection_timing_wheel.sv
// Idle-connection timing wheel: an activity item parks a connection in the
// current slot, a remove item stops tracking it, and a tick advances the slot
// and evicts every connection still parked there, in ascending order. A
// tick walks the whole slot RAM through its single read port, a read and
// a check per connection, and no new item is taken until the last result
// is pushed, which a stall on the result side can delay. Results leave
// through a one-entry output register. Depends on icw_pkg, icw_ctrl,
// icw_out_buf and the macros header.
`default_nettype none
`include "idle_connection_timing_wheel_macros.svh"
module idle_connection_timing_wheel (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              evt_valid,
    output logic                   evt_ready,
    input  wire icw_pkg::icw_evt_t evt,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output icw_pkg::icw_res_t      res
);

    icw_pkg::icw_push_t push;
    logic               out_free;

    icw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .out_free  (out_free),
        .push      (push)
    );

    icw_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .free      (out_free),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    `ICW_ASSERT_NEVER(a_push_when_full, push.load && !out_free)
    `ICW_ASSERT_NEXT(a_tick_goes_busy, evt_valid && evt_ready && evt.opcode == icw_pkg::OP_TICK, !evt_ready)
    `ICW_ASSERT_IMPLIES(a_more_after_non_last, res_valid && !res.last, !evt_ready)
    `ICW_ASSERT_IMPLIES(a_no_kick_is_final, push.load && !push.item.kick_valid, push.item.last && push.item.kicked_conn == '0)

endmodule
`default_nettype wire

// File: tb/tb_idle_connection_timing_wheel.sv
`timescale 1ns / 100ps
// Self-checking testbench for idle_connection_timing_wheel: drives event items
// through a valid/ready driver, predicts evictions with its own wheel model.
// Depends on icw_pkg and the idle_connection_timing_wheel RTL only.
module tb_idle_connection_timing_wheel;

    localparam logic [icw_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 260;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int TAIL_CYCLES = 2 * icw_pkg::MAX_CONN + 8;

    typedef struct {
        icw_pkg::icw_evt_t evt;
        bit                drain;
    } pend_evt_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic evt_valid = 1'b0;
    logic evt_ready;
    icw_pkg::icw_evt_t evt = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    icw_pkg::icw_res_t res;

    pend_evt_t evt_pend_q[$];
    icw_pkg::icw_res_t kick_exp_q[$];

    logic [icw_pkg::SLOT_W-1:0] cur_slot = '0;
    logic [icw_pkg::SLOT_W-1:0] park_slot [icw_pkg::MAX_CONN] = '{default: '0};
    bit tracked_conn [icw_pkg::MAX_CONN] = '{default: 1'b0};

    int cycle_cnt = 0;
    int err_cnt = 0;
    int stim_cnt = 0;
    bit quiet;
    bit send_gap;

    idle_connection_timing_wheel u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    assign quiet = (cycle_cnt >= 3000) && (cycle_cnt < 8000);

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic predict_wheel(input icw_pkg::icw_evt_t e);
        icw_pkg::icw_res_t r;
        int n;
        n = 0;
        case (e.opcode)
            icw_pkg::OP_TICK:
            begin
                cur_slot = (int'(cur_slot) == icw_pkg::WHEEL_SLOTS - 1) ? '0
                                                                        : cur_slot + 1'b1;
                for (int c = 0; c < icw_pkg::MAX_CONN; c++)
                begin
                    if (tracked_conn[c] && park_slot[c] == cur_slot)
                    begin
                        tracked_conn[c] = 1'b0;
                        r.kick_valid = 1'b1;
                        r.kicked_conn = icw_pkg::ID_W'(c);
                        r.last = 1'b0;
                        kick_exp_q.push_back(r);
                        n++;
                    end
                end
                if (n == 0)
                begin
                    r.kick_valid = 1'b0;
                    r.kicked_conn = '0;
                    r.last = 1'b1;
                    kick_exp_q.push_back(r);
                end
                else
                begin
                    r = kick_exp_q.pop_back();
                    r.last = 1'b1;
                    kick_exp_q.push_back(r);
                end
            end
            icw_pkg::OP_ACTIVE:
            begin
                if (int'(e.conn_id) < icw_pkg::MAX_CONN)
                begin
                    park_slot[e.conn_id] = cur_slot;
                    tracked_conn[e.conn_id] = 1'b1;
                end
            end
            icw_pkg::OP_REMOVE:
            begin
                if (int'(e.conn_id) < icw_pkg::MAX_CONN)
                    tracked_conn[e.conn_id] = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid <= 1'b0;
            evt <= '0;
        end
        else
        begin
            if (evt_valid && evt_ready)
                predict_wheel(evt);
            if (!evt_valid || evt_ready)
            begin
                send_gap = !quiet && ($urandom_range(99, 0) < 16);
                if (evt_pend_q.size() != 0 && !send_gap
                    && !(evt_pend_q[0].drain && kick_exp_q.size() != 0))
                begin
                    evt <= evt_pend_q[0].evt;
                    evt_valid <= 1'b1;
                    void'(evt_pend_q.pop_front());
                end
                else
                begin
                    evt_valid <= 1'b0;
                end
            end
        end
    end

    task automatic note_mismatch(input string what, input icw_pkg::icw_res_t exp_r,
                                 input icw_pkg::icw_res_t act_r);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%0t: %s: expected kick_valid=%0b conn=%0d last=%0b, got kick_valid=%0b conn=%0d last=%0b",
                     $realtime, what, exp_r.kick_valid, exp_r.kicked_conn, exp_r.last,
                     act_r.kick_valid, act_r.kicked_conn, act_r.last);
    endtask

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        icw_pkg::icw_res_t exp_r;
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (kick_exp_q.size() == 0)
                begin
                    note_mismatch("unexpected result", '0, res);
                end
                else
                begin
                    exp_r = kick_exp_q.pop_front();
                    if (res.kick_valid !== exp_r.kick_valid
                        || res.kicked_conn !== exp_r.kicked_conn
                        || res.last !== exp_r.last)
                        note_mismatch("result mismatch", exp_r, res);
                end
            end
            res_ready <= quiet || ($urandom_range(99, 0) >= 16);
        end
    end

    task automatic push_evt(input logic [icw_pkg::OP_W-1:0] op, input int id,
                            input bit drain);
        pend_evt_t p;
        p.evt.opcode = op;
        p.evt.conn_id = icw_pkg::ID_W'(id);
        p.drain = drain;
        evt_pend_q.push_back(p);
        if (op != OP_UNUSED)
            stim_cnt++;
    endtask

    initial
    begin
        int pick;
        int n;
        int base;

        // empty tick, park, re-park in same slot, removes, ignored opcode
        push_evt(icw_pkg::OP_TICK, 0, 1'b0);
        push_evt(icw_pkg::OP_ACTIVE, 0, 1'b0);
        push_evt(icw_pkg::OP_ACTIVE, 63, 1'b0);
        push_evt(icw_pkg::OP_ACTIVE, 21, 1'b0);
        push_evt(icw_pkg::OP_ACTIVE, 42, 1'b0);
        push_evt(icw_pkg::OP_ACTIVE, 21, 1'b0);
        push_evt(icw_pkg::OP_REMOVE, 42, 1'b0);
        push_evt(icw_pkg::OP_REMOVE, 42, 1'b0);
        push_evt(icw_pkg::OP_REMOVE, 10, 1'b0);
        push_evt(OP_UNUSED, 63, 1'b0);
        push_evt(icw_pkg::OP_TICK, 63, 1'b0);
        push_evt(icw_pkg::OP_ACTIVE, 0, 1'b0);
        push_evt(icw_pkg::OP_ACTIVE, 5, 1'b0);
        push_evt(icw_pkg::OP_REMOVE, 63, 1'b0);
        push_evt(icw_pkg::OP_TICK, 42, 1'b0);
        base = stim_cnt;

        // fill every connection, then a full turn to evict them all in one tick
        for (int i = 0; i < icw_pkg::MAX_CONN; i++)
            push_evt(icw_pkg::OP_ACTIVE, i, i == 0);
        for (int i = 0; i < icw_pkg::WHEEL_SLOTS; i++)
            push_evt(icw_pkg::OP_TICK, $urandom_range(63, 0), 1'b0);

        while (stim_cnt < base + RANDOM_ITEMS)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 8)
            begin
                n = $urandom_range(16, 2);
                for (int i = 0; i < n; i++)
                    push_evt(icw_pkg::OP_ACTIVE, $urandom_range(63, 0), 1'b0);
            end
            else if (pick < 14)
            begin
                n = $urandom_range(icw_pkg::WHEEL_SLOTS, 5);
                for (int i = 0; i < n; i++)
                    push_evt(icw_pkg::OP_TICK, $urandom_range(63, 0), 1'b0);
            end
            else
            begin
                pick = $urandom_range(99, 0);
                if (pick < 40)
                    push_evt(icw_pkg::OP_TICK, $urandom_range(63, 0), 1'b0);
                else if (pick < 82)
                    push_evt(icw_pkg::OP_ACTIVE, $urandom_range(63, 0), 1'b0);
                else if (pick < 96)
                    push_evt(icw_pkg::OP_REMOVE, $urandom_range(63, 0), 1'b0);
                else
                    push_evt(OP_UNUSED, $urandom_range(63, 0), 1'b0);
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (evt_pend_q.size() != 0 || evt_valid)
            @(posedge clk);
        while (kick_exp_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
